### rtl/vips_pkg.sv
package vips_pkg;

	// Operation carried by each request.
	typedef enum logic [1:0] {
		OP_COMMAND = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_CAPTURE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INTEGRATED = 3'd0,
		ST_HELD       = 3'd1,
		ST_STAGED     = 3'd2,
		ST_COMMITTED  = 3'd3,
		ST_REJECTED   = 3'd4,
		ST_CAPTURED   = 3'd5
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_JOINT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
	localparam logic [1:0] CFG_MAX_VELOCITY = 2'd2;
	localparam logic [1:0] CFG_MAX_LEAD     = 2'd3;

	// Configuration reset values.
	localparam logic [3:0]  RST_JOINT_COUNT  = 4'd8;
	localparam logic [31:0] RST_TIMEOUT      = 32'd104858;
	localparam logic [30:0] RST_MAX_VELOCITY = 31'd0;
	localparam logic [30:0] RST_MAX_LEAD     = 31'd3277;

	// The staged element count saturates here on over-long messages.
	localparam logic [3:0] STAGED_COUNT_MAX = 4'd15;

	// Fraction bits dropped from velocity times period.
	localparam int unsigned PERIOD_SHIFT = 20;

	typedef struct packed {
		logic [3:0]  joint_count;
		logic [31:0] timeout;
		logic [30:0] max_velocity;
		logic [30:0] max_lead;
	} cfg_t;

endpackage

### rtl/vips_cfg.sv
module vips_cfg
	import vips_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Register file, written one register per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.joint_count  <= RST_JOINT_COUNT;
			cfg_q.timeout      <= RST_TIMEOUT;
			cfg_q.max_velocity <= RST_MAX_VELOCITY;
			cfg_q.max_lead     <= RST_MAX_LEAD;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_JOINT_COUNT:  cfg_q.joint_count  <= wr_data[3:0];
				CFG_TIMEOUT:      cfg_q.timeout      <= wr_data;
				CFG_MAX_VELOCITY: cfg_q.max_velocity <= wr_data[30:0];
				CFG_MAX_LEAD:     cfg_q.max_lead     <= wr_data[30:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/vips_integrator.sv
module vips_integrator
	import vips_pkg::*;
(
	input  logic signed [31:0] ref_in,
	input  logic signed [31:0] velocity,
	input  logic        [19:0] period,
	input  logic signed [31:0] position,
	input  logic        [30:0] max_lead,
	output logic signed [31:0] ref_out
);

	localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
	localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

	logic signed [52:0] product;
	logic signed [32:0] step;
	logic signed [33:0] sum;
	logic signed [33:0] sat;
	logic signed [33:0] hi;
	logic signed [33:0] lo;
	logic signed [33:0] clamped;

	// Velocity times period; dropping the low bits of a signed product floors it.
	assign product = velocity * $signed({1'b0, period});
	assign step    = product[52:PERIOD_SHIFT];
	assign sum     = {{2{ref_in[31]}}, ref_in} + {step[32], step};

	// Saturate to 32 bits, then keep within a nonzero max_lead of the measurement.
	always_comb begin
		if (sum > S32_MAX) begin
			sat = S32_MAX;
		end else if (sum < S32_MIN) begin
			sat = S32_MIN;
		end else begin
			sat = sum;
		end
		hi = {{2{position[31]}}, position} + $signed({3'b000, max_lead});
		lo = {{2{position[31]}}, position} - $signed({3'b000, max_lead});
		clamped = sat;
		if (max_lead != 31'd0) begin
			if (clamped > hi) begin
				clamped = hi;
			end
			if (clamped < lo) begin
				clamped = lo;
			end
		end
	end

	assign ref_out = clamped[31:0];

endmodule

### rtl/velocity_integrating_position_servo_core.sv
// Position servo for up to MAX_JOINTS joints. Velocity commands arrive as
// messages of elements (operation 0, one per joint, last set on the final one)
// and are committed only when their length equals joint_count. Update
// elements (operation 1) integrate velocity times period into each joint's
// reference while the command is fresh; capture (operation 2) loads the
// measured position and drops the command. Every request yields exactly one
// result. One request is taken per clock cycle unless the output stalls; a
// request passes through the input register, then the result register, and
// the path between them is the velocity-period multiply followed by the add,
// saturate and lead clamp. The configuration port is always ready.
module velocity_integrating_position_servo_core
	import vips_pkg::*;
#(
	parameter int unsigned MAX_JOINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [2:0]         joint,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] position,
	input  logic [19:0]        period,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         joint_out,
	output logic signed [31:0] reference,
	output logic [2:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int unsigned IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	cfg_t cfg;

	// Input register.
	logic               valid_s1;
	op_t                op_s1;
	logic [2:0]         joint_s1;
	logic signed [31:0] velocity_s1;
	logic signed [31:0] position_s1;
	logic [19:0]        period_s1;
	logic               last_s1;

	// Servo state.
	logic signed [31:0] pref_q [MAX_JOINTS];
	logic signed [31:0] active_q [MAX_JOINTS];
	logic signed [31:0] staged_q [MAX_JOINTS];
	logic [3:0]         staged_count_q;
	logic               have_cmd_q;
	logic [31:0]        age_q;
	logic               pass_start_q;

	// Result register.
	logic               out_valid_q;
	logic [2:0]         res_joint_q;
	logic signed [31:0] res_ref_q;
	status_t            res_status_q;

	logic               adv;
	logic               fire;
	logic [4:0]         joint_x;
	logic [IW-1:0]      j_idx;
	logic               j_in;
	logic signed [31:0] held;
	logic signed [31:0] mv;
	logic signed [31:0] vclamp;
	logic [4:0]         count_x;
	logic [IW-1:0]      c_idx;
	logic               c_in;
	logic [3:0]         count_next;
	logic               jc_ok;
	logic               commit;
	logic [32:0]        age_sum;
	logic [31:0]        age_new;
	logic [31:0]        age_eff;
	logic               servo;
	logic signed [31:0] integ_ref;

	logic               pref_we;
	logic signed [31:0] pref_wdata;
	logic [2:0]         res_joint;
	logic signed [31:0] res_ref;
	status_t            res_status;

	vips_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// Handshake: the working stage moves on whenever the result register is free
	// or being emptied.
	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1       <= op_t'(operation);
			joint_s1    <= joint;
			velocity_s1 <= velocity;
			position_s1 <= position;
			period_s1   <= period;
			last_s1     <= last;
		end
	end

	// Joint addressing and the held reference.
	assign joint_x = {2'b00, joint_s1};
	assign j_idx   = joint_x[IW-1:0];
	assign j_in    = joint_x < 5'(MAX_JOINTS);
	assign held    = j_in ? pref_q[j_idx] : 32'sd0;

	// Velocity clamp for command elements.
	assign mv = $signed({1'b0, cfg.max_velocity});
	always_comb begin
		vclamp = velocity_s1;
		if (cfg.max_velocity != 31'd0) begin
			if (vclamp > mv) begin
				vclamp = mv;
			end
			if (vclamp < -mv) begin
				vclamp = -mv;
			end
		end
	end

	// Staging count and the commit decision.
	assign count_x    = {1'b0, staged_count_q};
	assign c_idx      = count_x[IW-1:0];
	assign c_in       = count_x < 5'(MAX_JOINTS);
	assign count_next = (staged_count_q < STAGED_COUNT_MAX) ?
		staged_count_q + 4'd1 : staged_count_q;
	assign jc_ok  = (cfg.joint_count != 4'd0) &&
		({1'b0, cfg.joint_count} <= 5'(MAX_JOINTS));
	assign commit = last_s1 && jc_ok && (count_next == cfg.joint_count);

	// Command age, advanced on the first element of each update pass.
	assign age_sum = {1'b0, age_q} + {13'd0, period_s1};
	assign age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
	assign age_eff = pass_start_q ? age_new : age_q;
	assign servo   = ({1'b0, joint_s1} < cfg.joint_count) && j_in &&
		have_cmd_q && (age_eff <= cfg.timeout);

	vips_integrator u_integrator (
		.ref_in   (held),
		.velocity (j_in ? active_q[j_idx] : 32'sd0),
		.period   (period_s1),
		.position (position_s1),
		.max_lead (cfg.max_lead),
		.ref_out  (integ_ref)
	);

	// Result and reference write for the request in the working stage.
	always_comb begin
		pref_we    = 1'b0;
		pref_wdata = integ_ref;
		res_joint  = joint_s1;
		res_ref    = held;
		res_status = ST_HELD;
		unique case (op_s1)
			OP_COMMAND: begin
				res_joint  = 3'd0;
				res_ref    = 32'sd0;
				res_status = last_s1 ? (commit ? ST_COMMITTED : ST_REJECTED) : ST_STAGED;
			end
			OP_UPDATE: begin
				if (servo) begin
					pref_we    = j_in;
					res_ref    = integ_ref;
					res_status = ST_INTEGRATED;
				end
			end
			OP_CAPTURE: begin
				pref_we    = j_in;
				pref_wdata = position_s1;
				res_ref    = position_s1;
				res_status = ST_CAPTURED;
			end
			OP_UNUSED: begin
				res_status = ST_HELD;
			end
		endcase
	end

	// Staged velocities need no reset: only entries of the current message are read.
	always_ff @(posedge clk) begin
		if (fire && op_s1 == OP_COMMAND && c_in) begin
			staged_q[c_idx] <= vclamp;
		end
	end

	// Per-joint references and the active command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOINTS; i++) begin
				pref_q[i]   <= 32'sd0;
				active_q[i] <= 32'sd0;
			end
		end else if (fire) begin
			if (pref_we) begin
				pref_q[j_idx] <= pref_wdata;
			end
			if (op_s1 == OP_COMMAND && commit) begin
				for (int i = 0; i < MAX_JOINTS; i++) begin
					if (5'(i) < {1'b0, cfg.joint_count}) begin
						active_q[i] <= (c_in && c_idx == IW'(i)) ? vclamp : staged_q[i];
					end
				end
			end
		end
	end

	// Message and timing control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staged_count_q <= 4'd0;
			have_cmd_q     <= 1'b0;
			age_q          <= 32'd0;
			pass_start_q   <= 1'b1;
		end else if (fire) begin
			unique case (op_s1)
				OP_COMMAND: begin
					staged_count_q <= last_s1 ? 4'd0 : count_next;
					if (commit) begin
						have_cmd_q <= 1'b1;
						age_q      <= 32'd0;
					end
				end
				OP_UPDATE: begin
					age_q        <= age_eff;
					pass_start_q <= last_s1;
				end
				OP_CAPTURE: begin
					have_cmd_q <= 1'b0;
				end
				OP_UNUSED: begin
					have_cmd_q <= have_cmd_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_joint_q  <= res_joint;
			res_ref_q    <= res_ref;
			res_status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign joint_out = res_joint_q;
	assign reference = res_ref_q;
	assign status    = res_status_q;

	// An integrated result can only come from a held command.
	a_integrated_needs_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_status_q == ST_INTEGRATED |-> have_cmd_q)
		else $error("integrated result without an active command");

	// A finished message always leaves the staging count empty.
	a_message_end_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_status_q == ST_COMMITTED || res_status_q == ST_REJECTED)
		|-> staged_count_q == 4'd0)
		else $error("staging count not cleared at end of message");

	// A commit restarts the command age and raises the command flag.
	a_commit_restarts_age: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_status_q == ST_COMMITTED |-> age_q == 32'd0 && have_cmd_q)
		else $error("commit did not restart the command age");

endmodule

### test/velocity_integrating_position_servo_core_tb.sv
`timescale 1ns / 1ps

module velocity_integrating_position_servo_core_tb;
	import vips_pkg::*;

	localparam int unsigned JOINTS = 8;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RESULT_LATENCY = 2;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned LONG_HOLD = 300;
	localparam longint signed S32_MAX = 64'sd2147483647;
	localparam longint signed S32_MIN = -64'sd2147483648;

	typedef struct {
		op_t                op;
		logic [2:0]         joint;
		logic signed [31:0] velocity;
		logic signed [31:0] position;
		logic [19:0]        period;
		logic               last;
	} request_t;

	typedef struct {
		logic [2:0]         joint_out;
		logic signed [31:0] reference;
		status_t            status;
	} servo_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = OP_COMMAND;
	logic [2:0]         joint = '0;
	logic signed [31:0] velocity = '0;
	logic signed [31:0] position = '0;
	logic [19:0]        period = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         joint_out;
	logic signed [31:0] reference;
	logic [2:0]         status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_JOINT_COUNT;
	logic [31:0]        cfg_data = '0;

	velocity_integrating_position_servo_core u_dut (.*);

	// Tracked copy of the servo state and its registers.
	cfg_t               servo_cfg;
	logic signed [31:0] ref_track [JOINTS];
	logic signed [31:0] staged_vel [JOINTS];
	logic signed [31:0] active_vel [JOINTS];
	logic [3:0]         staged_len;
	logic               command_live;
	logic [31:0]        command_age;
	logic               pass_open;

	request_t      pending_requests [$];
	servo_result_t awaited_results [$];
	request_t      next_rq;

	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;
	int unsigned send_gap = 0;
	logic        send_idle = 1'b1;
	int unsigned recv_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_requests = 0;
	logic        recv_idle = 1'b1;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned requests_taken = 0;
	int unsigned settings_applied = 0;
	int unsigned status_tally [8];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	function automatic void reset_servo_model();
		servo_cfg.joint_count = RST_JOINT_COUNT;
		servo_cfg.timeout = RST_TIMEOUT;
		servo_cfg.max_velocity = RST_MAX_VELOCITY;
		servo_cfg.max_lead = RST_MAX_LEAD;
		for (int k = 0; k < JOINTS; k++) begin
			ref_track[k] = '0;
			staged_vel[k] = '0;
			active_vel[k] = '0;
		end
		staged_len = '0;
		command_live = 1'b0;
		command_age = '0;
		pass_open = 1'b1;
	endfunction

	function automatic void apply_register(input logic [1:0] index, input logic [31:0] data);
		case (index)
		CFG_JOINT_COUNT: servo_cfg.joint_count = data[3:0];
		CFG_TIMEOUT: servo_cfg.timeout = data;
		CFG_MAX_VELOCITY: servo_cfg.max_velocity = data[30:0];
		CFG_MAX_LEAD: servo_cfg.max_lead = data[30:0];
		default: ;
		endcase
	endfunction

	// Works out the result of one request and advances the tracked state.
	function automatic servo_result_t predict_servo_result(input request_t rq);
		servo_result_t res;
		longint signed vel, lim, acc, step, lo, hi;
		logic [63:0] age_sum;
		int unsigned k;
		res.joint_out = '0;
		res.reference = '0;
		res.status = ST_HELD;
		case (rq.op)
		OP_COMMAND: begin
			// Clamp and stage the element; the message closes on its last element.
			vel = rq.velocity;
			lim = {33'd0, servo_cfg.max_velocity};
			if (lim != 0) begin
				if (vel > lim) vel = lim;
				if (vel < -lim) vel = -lim;
			end
			if (staged_len < JOINTS) staged_vel[staged_len[2:0]] = vel[31:0];
			if (staged_len < STAGED_COUNT_MAX) staged_len = staged_len + 4'd1;
			if (rq.last) begin
				if (servo_cfg.joint_count >= 1 && servo_cfg.joint_count <= JOINTS &&
						staged_len == servo_cfg.joint_count) begin
					for (k = 0; k < servo_cfg.joint_count; k++) active_vel[k] = staged_vel[k];
					command_live = 1'b1;
					command_age = '0;
					res.status = ST_COMMITTED;
				end else begin
					res.status = ST_REJECTED;
				end
				staged_len = '0;
			end else begin
				res.status = ST_STAGED;
			end
		end
		OP_UPDATE: begin
			// The age moves on once per pass, at its first element.
			if (pass_open) begin
				age_sum = {32'd0, command_age} + {44'd0, rq.period};
				command_age = (age_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : age_sum[31:0];
			end
			pass_open = rq.last;
			res.joint_out = rq.joint;
			if (rq.joint < servo_cfg.joint_count && command_live &&
					command_age <= servo_cfg.timeout) begin
				step = longint'(active_vel[rq.joint]) * longint'({1'b0, rq.period});
				step = step >>> PERIOD_SHIFT;
				acc = longint'(ref_track[rq.joint]) + step;
				if (acc > S32_MAX) acc = S32_MAX;
				if (acc < S32_MIN) acc = S32_MIN;
				lim = {33'd0, servo_cfg.max_lead};
				if (lim != 0) begin
					hi = longint'(rq.position) + lim;
					lo = longint'(rq.position) - lim;
					if (acc > hi) acc = hi;
					if (acc < lo) acc = lo;
				end
				ref_track[rq.joint] = acc[31:0];
				res.reference = acc[31:0];
				res.status = ST_INTEGRATED;
			end else begin
				res.reference = ref_track[rq.joint];
				res.status = ST_HELD;
			end
		end
		OP_CAPTURE: begin
			ref_track[rq.joint] = rq.position;
			command_live = 1'b0;
			res.joint_out = rq.joint;
			res.reference = rq.position;
			res.status = ST_CAPTURED;
		end
		default: begin
			res.joint_out = rq.joint;
			res.reference = ref_track[rq.joint];
			res.status = ST_HELD;
		end
		endcase
		return res;
	endfunction

	// Monitor: checks results, tracks register writes and predicts each accepted request.
	always @(posedge clk) begin
		servo_result_t want;
		request_t seen;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Unexpected result: joint %0d reference %0d status %0d",
							joint_out, reference, status);
				end else begin
					want = awaited_results.pop_front();
					if (joint_out !== want.joint_out || reference !== want.reference ||
							status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("Mismatch: expected joint %0d ref %0d status %0d, got %0d %0d %0d",
								want.joint_out, want.reference, want.status,
								joint_out, reference, status);
					end
				end
			end
			if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				seen = '{op_t'(operation), joint, velocity, position, period, last};
				want = predict_servo_result(seen);
				status_tally[want.status]++;
				awaited_results.insert(awaited_results.size(), want);
				requests_taken++;
			end
		end
	end

	// Request driver: presents queued requests, with a drawn gap after each one.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() != 0) begin
				next_rq = pending_requests.pop_front();
				operation <= next_rq.op;
				joint <= next_rq.joint;
				velocity <= next_rq.velocity;
				position <= next_rq.position;
				period <= next_rq.period;
				last <= next_rq.last;
				in_valid <= 1'b1;
				send_gap <= send_idle ? $urandom_range(0, 11) : 0;
				if ($urandom_range(0, 47) == 0) send_idle <= !send_idle;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stalls for a drawn count after each result, or for a long hold-off.
	always @(negedge clk) begin
		int unsigned wait_cycles;
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (out_taken) begin
			wait_cycles = recv_idle ? $urandom_range(0, 11) : 0;
			out_stall <= (wait_cycles != 0);
			recv_left <= (wait_cycles != 0) ? wait_cycles - 1 : 0;
			if ($urandom_range(0, 47) == 0) recv_idle <= !recv_idle;
		end else if (recv_left > 0) begin
			recv_left <= recv_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_register(input logic [1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [3:0] count, input logic [31:0] limit,
			input logic [30:0] vmax, input logic [30:0] lead);
		write_register(CFG_JOINT_COUNT, {28'd0, count});
		write_register(CFG_TIMEOUT, limit);
		write_register(CFG_MAX_VELOCITY, {1'b0, vmax});
		write_register(CFG_MAX_LEAD, {1'b0, lead});
		settings_applied++;
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	// Holds off new requests until every awaited result has come back.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	// Appends one request to the tail of the pending queue.
	function automatic void add_request(input request_t rq);
		pending_requests.insert(pending_requests.size(), rq);
	endfunction

	function automatic logic signed [31:0] random_velocity();
		case ($urandom_range(0, 15))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return $urandom;
		3: return '0;
		default: return $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] random_position();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
	endfunction

	function automatic logic [19:0] random_period();
		case ($urandom_range(0, 15))
		0: return '0;
		1: return 20'hFFFFF;
		2: return 20'($urandom_range(0, 20'hFFFFF));
		default: return 20'($urandom_range(1, 4095));
		endcase
	endfunction

	function automatic void queue_message(input int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			add_request('{OP_COMMAND, 3'($urandom_range(0, 7)), random_velocity(),
				random_position(), random_period(), 1'(k == len - 1)});
	endfunction

	function automatic void queue_pass(input int unsigned len);
		logic [19:0] per;
		per = random_period();
		for (int unsigned k = 0; k < len; k++)
			add_request('{OP_UPDATE,
				($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'(k),
				$urandom, random_position(), per, 1'(k == len - 1)});
	endfunction

	// One random stretch of traffic: mostly well-formed messages and passes.
	function automatic int unsigned queue_episode();
		int unsigned count, len, pick;
		count = (servo_cfg.joint_count >= 1 && servo_cfg.joint_count <= JOINTS) ?
			servo_cfg.joint_count : $urandom_range(1, JOINTS);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			len = count;
			queue_message(len);
		end else if (pick < 70) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, JOINTS) : count;
			queue_pass(len);
		end else if (pick < 78) begin
			len = 1;
			add_request('{OP_CAPTURE, 3'($urandom_range(0, 7)), $urandom,
				random_position(), random_period(), 1'($urandom_range(0, 1))});
		end else if (pick < 88) begin
			// Messages of random length, mostly wrong, some long enough to saturate the count.
			len = $urandom_range(1, 18);
			queue_message(len);
		end else begin
			len = $urandom_range(1, 3);
			for (int unsigned k = 0; k < len; k++)
				add_request('{op_t'($urandom_range(0, 3)),
					3'($urandom_range(0, 7)), $urandom, $urandom,
					20'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1))});
		end
		return len;
	endfunction

	task automatic run_random(input int unsigned count);
		int unsigned pushed;
		pushed = 0;
		while (pushed < count) pushed += queue_episode();
		wait_drained();
	endtask

	// Main sequence.
	initial begin
		reset_servo_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed requests under the reset settings.
		add_request('{OP_UPDATE, 3'd0, 32'sd0, 32'sd0, 20'hFFFFF, 1'b1});
		add_request('{OP_UNUSED, 3'd7, -32'sd1, 32'sh7FFF_FFFF, 20'd5, 1'b0});
		add_request('{OP_COMMAND, 3'd0, 32'sh7FFF_FFFF, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd1, 32'sh8000_0000, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd2, 32'sd0, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd3, -32'sd1, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd4, 32'sd1048576, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd5, -32'sd1048576, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd6, 32'sd12345, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd7, -32'sd98765, 32'sd0, 20'd0, 1'b1});
		add_request('{OP_UPDATE, 3'd0, 32'sd0, 32'sh7FFF_FFFF, 20'd1024, 1'b0});
		add_request('{OP_UPDATE, 3'd1, 32'sd0, 32'sh8000_0000, 20'd1024, 1'b0});
		for (int k = 2; k < JOINTS; k++)
			add_request('{OP_UPDATE, 3'(k), 32'sd0, 32'sd1000, 20'd1024,
				1'(k == JOINTS - 1)});
		add_request('{OP_CAPTURE, 3'd3, 32'sd0, 32'sh7FFF_FFFF, 20'd0, 1'b1});
		add_request('{OP_UPDATE, 3'd3, 32'sd0, 32'sh7FFF_FFFF, 20'd0, 1'b1});
		add_request('{OP_COMMAND, 3'd0, 32'sd77, 32'sd0, 20'd0, 1'b0});
		add_request('{OP_COMMAND, 3'd0, -32'sd77, 32'sd0, 20'd0, 1'b1});
		add_request('{OP_CAPTURE, 3'd5, 32'sd0, 32'sh8000_0000, 20'd0, 1'b0});
		wait_drained();

		run_random(300);

		// Few joints, no lead clamp; the receiver holds off while requests keep coming.
		apply_settings(4'd3, 32'd2000000, 31'd3145728, 31'd0);
		@(posedge clk);
		hold_requests++;
		run_random(250);

		// Timeout of one, smallest nonzero clamp and lead, with a single joint.
		apply_settings(4'd1, 32'd1, 31'd1, 31'd1);
		run_random(200);

		// Largest settings: the command never goes stale.
		apply_settings(4'd8, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		run_random(250);

		// Joint counts that no message can match.
		apply_settings(4'd0, 32'd104858, 31'd0, 31'd3277);
		run_random(80);
		apply_settings(4'd15, 32'h00FF_FFFF, 31'd16777216, 31'd1048576);
		run_random(80);

		for (int n = 0; n < 2; n++) begin
			apply_settings(4'($urandom_range(1, JOINTS)), $urandom | 32'd1,
				31'($urandom_range(0, 32'h00FF_FFFF)), 31'($urandom_range(0, 65535)));
			run_random(125);
		end

		wait_drained();
		$display("Run covered %0d requests over %0d register settings.",
			requests_taken, settings_applied + 1);
		$display("Results: %0d integrated, %0d held, %0d committed, %0d rejected, %0d captured.",
			status_tally[ST_INTEGRATED], status_tally[ST_HELD], status_tally[ST_COMMITTED],
			status_tally[ST_REJECTED], status_tally[ST_CAPTURED]);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				awaited_results.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
